// ----- rtl/alarm_table_matcher_macros.svh -----
// Assertion macros for the alarm table matcher.
// Used by the top level only; no other dependencies.
`ifndef ALARM_TABLE_MATCHER_MACROS_SVH
`define ALARM_TABLE_MATCHER_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ATM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Condition that must never be seen outside reset.
`define ATM_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define ATM_ASSERT(lbl, prop, msg)
`define ATM_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ----- rtl/atm_pkg.sv -----
// Shared types and constants for the alarm table matcher.
// Used by atm_cell and alarm_table_matcher; depends on nothing.
`default_nettype none

package atm_pkg;

   localparam int NUM_ALARMS       = 8;
   localparam int COUNT_W          = $clog2(NUM_ALARMS + 1);
   localparam int CMP_W            = (COUNT_W > 4) ? COUNT_W : 4;
   localparam int TIMEOUT_W        = 11;
   localparam int TIMEOUT_RESET    = 30;
   localparam int HOURS_PER_DAY    = 24;
   localparam int MINUTES_PER_HOUR = 60;
   localparam int ELAPSED_W        = 13;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_ADD     = 3'd1,
      OP_MODIFY  = 3'd2,
      OP_SET_EN  = 3'd3,
      OP_CLEAR   = 3'd4,
      OP_ACK     = 3'd5
   } op_type;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_FULL  = 2'd1;
   localparam logic [1:0] ERR_INDEX = 2'd2;

   // Register index as decoded from the word address bit.
   localparam logic CSR_IDX_TIMEOUT = 1'b0;

   typedef struct packed {
      logic [2:0] opcode;
      logic [2:0] entry_index;
      logic [4:0] hour_value;
      logic [5:0] minute_value;
      logic       enable_value;
   } req_type;

   typedef struct packed {
      logic       start_ring;
      logic       stop_ring;
      logic       ringing;
      logic [3:0] alarm_count;
      logic [1:0] error_code;
   } rsp_type;

   // Item as it travels down the row of cells, gathering flags on the way.
   typedef struct packed {
      logic [2:0]         op;
      logic [2:0]         idx;
      logic [4:0]         hv;
      logic [5:0]         mv;
      logic               ev;
      logic [COUNT_W-1:0] count_before;
      logic [COUNT_W-1:0] count_after;
      logic [1:0]         err;
      logic               start;
      logic               stop;
      logic               any;
   } token_type;

endpackage

`default_nettype wire

// ----- rtl/alarm_table_matcher.sv -----
// Alarm table matcher: an item walks a row of NUM_ALARMS entry cells, one cell per cycle.
// An accepted item is registered in each cell in turn, then goes to the output register.
// Only one item is in the row at a time: a new one is accepted once the last has left it and the skid stage is empty.
// A finished result waits in an output register with one skid stage behind it.
// Synchronous active-high reset clears flags and the alarm count and sets the timeout to 30.
`default_nettype none
`include "alarm_table_matcher_macros.svh"

module alarm_table_matcher (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  atm_pkg::req_type       req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output atm_pkg::rsp_type       rsp_payload,
   input  wire                    psel,
   input  wire                    penable,
   input  wire                    pwrite,
   input  wire  [2:0]             paddr,
   input  wire  [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import atm_pkg::*;

   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 in_flight_ff, in_flight_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 skid_valid_ff, skid_valid_in;
   rsp_type              skid_ff, skid_in;

   token_type            chain_tok   [NUM_ALARMS+1];
   logic                 chain_valid [NUM_ALARMS+1];

   logic                 req_take, rsp_take, csr_write, chain_done;
   logic [COUNT_W-1:0]   count_after;
   logic [1:0]           err;
   logic [CMP_W-1:0]     done_count_ext;
   rsp_type              done_rsp;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == CSR_IDX_TIMEOUT) ? 32'(timeout_ff) : 32'd0;
   assign timeout_in = (csr_write && (paddr[2] == CSR_IDX_TIMEOUT)) ?
                       pwdata[TIMEOUT_W-1:0] : timeout_ff;

   assign req_ready  = !in_flight_ff && !skid_valid_ff;
   assign req_take   = req_valid && req_ready;
   assign rsp_take   = rsp_valid_ff && rsp_ready;
   assign chain_done = chain_valid[NUM_ALARMS];

   // Table-level checks and the new count are settled here; cells only see the outcome.
   always_comb begin
      count_after = count_ff;
      err         = ERR_OK;
      case (req_payload.opcode)
         OP_ADD: begin
            if (count_ff >= COUNT_W'(NUM_ALARMS)) begin
               err = ERR_FULL;
            end else begin
               count_after = count_ff + COUNT_W'(1);
            end
         end
         OP_MODIFY, OP_SET_EN: begin
            if (CMP_W'(req_payload.entry_index) >= CMP_W'(count_ff)) begin
               err = ERR_INDEX;
            end
         end
         OP_CLEAR: begin
            count_after = '0;
         end
         default: begin
         end
      endcase

      chain_valid[0]            = req_take;
      chain_tok[0].op           = req_payload.opcode;
      chain_tok[0].idx          = req_payload.entry_index;
      chain_tok[0].hv           = req_payload.hour_value;
      chain_tok[0].mv           = req_payload.minute_value;
      chain_tok[0].ev           = req_payload.enable_value;
      chain_tok[0].count_before = count_ff;
      chain_tok[0].count_after  = count_after;
      chain_tok[0].err          = err;
      chain_tok[0].start        = 1'b0;
      chain_tok[0].stop         = 1'b0;
      chain_tok[0].any          = 1'b0;
   end

   for (genvar k = 0; k < NUM_ALARMS; k++) begin : g_cell
      atm_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .cell_id       (COUNT_W'(k)),
         .timeout       (timeout_ff),
         .tok_in_valid  (chain_valid[k]),
         .tok_in        (chain_tok[k]),
         .tok_out_valid (chain_valid[k+1]),
         .tok_out       (chain_tok[k+1])
      );
   end

   always_comb begin
      done_count_ext        = CMP_W'(chain_tok[NUM_ALARMS].count_after);
      done_rsp.start_ring   = chain_tok[NUM_ALARMS].start;
      done_rsp.stop_ring    = chain_tok[NUM_ALARMS].stop;
      done_rsp.ringing      = chain_tok[NUM_ALARMS].any;
      done_rsp.alarm_count  = done_count_ext[3:0];
      done_rsp.error_code   = chain_tok[NUM_ALARMS].err;

      count_in      = req_take ? count_after : count_ff;
      in_flight_in  = in_flight_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;

      if (req_take) begin
         in_flight_in = 1'b1;
      end else if (chain_done) begin
         in_flight_in = 1'b0;
      end

      if (chain_done) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_in       = done_rsp;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = done_rsp;
         end
      end else if (rsp_take) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_W'(TIMEOUT_RESET);
         count_ff      <= '0;
         in_flight_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         timeout_ff    <= timeout_in;
         count_ff      <= count_in;
         in_flight_ff  <= in_flight_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A finished item must belong to one that was accepted and still counts as in flight.
   `ATM_ASSERT_NEVER(a_done_without_item, chain_done && !in_flight_ff, "item left row unowned")
   // The skid stage only fills behind a waiting result.
   `ATM_ASSERT(a_skid_behind_rsp, skid_valid_ff |-> rsp_valid_ff, "skid full, output empty")
   // The stored count never runs past the table size.
   `ATM_ASSERT(a_count_bound, count_ff <= COUNT_W'(NUM_ALARMS), "alarm count over table size")
   // An accepted item keeps the row busy on the following cycle.
   `ATM_ASSERT(a_accept_busy, req_take |=> in_flight_ff, "accepted item not in flight")

endmodule

`default_nettype wire

// ----- rtl/atm_cell.sv -----
// One alarm entry of the matcher row: holds the entry state, applies the
// passing item to it and hands the item on. Depends on atm_pkg.
`default_nettype none

module atm_cell (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  [atm_pkg::COUNT_W-1:0]       cell_id,
   input  wire  [atm_pkg::TIMEOUT_W-1:0]     timeout,
   input  wire                               tok_in_valid,
   input  atm_pkg::token_type                tok_in,
   output logic                              tok_out_valid,
   output atm_pkg::token_type                tok_out
);
   import atm_pkg::*;

   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic        enabled_ff, enabled_in;
   logic        ringing_ff, ringing_in;
   logic        acked_ff, acked_in;
   logic        valid_ff;
   token_type   tok_ff, tok_in_nxt;

   logic [CMP_W-1:0]            id_ext, idx_ext, cb_ext, ca_ext;
   logic                        stored, addressed, matched, timed_out;
   logic signed [ELAPSED_W-1:0] hdiff, mdiff, elapsed, tmo_s;

   always_comb begin
      id_ext    = CMP_W'(cell_id);
      idx_ext   = CMP_W'(tok_in.idx);
      cb_ext    = CMP_W'(tok_in.count_before);
      ca_ext    = CMP_W'(tok_in.count_after);
      stored    = id_ext < cb_ext;
      addressed = stored && (id_ext == idx_ext);
      matched   = (tok_in.hv == hour_ff) && (tok_in.mv == minute_ff);

      // Elapsed minutes since the alarm time; an earlier hour means the day wrapped.
      if (tok_in.hv < hour_ff) begin
         hdiff = ELAPSED_W'(tok_in.hv) + ELAPSED_W'(HOURS_PER_DAY) - ELAPSED_W'(hour_ff);
      end else begin
         hdiff = ELAPSED_W'(tok_in.hv) - ELAPSED_W'(hour_ff);
      end
      mdiff     = ELAPSED_W'(tok_in.mv) - ELAPSED_W'(minute_ff);
      elapsed   = hdiff * $signed(ELAPSED_W'(MINUTES_PER_HOUR)) + mdiff;
      tmo_s     = ELAPSED_W'(timeout);
      timed_out = elapsed > tmo_s;

      hour_in    = hour_ff;
      minute_in  = minute_ff;
      enabled_in = enabled_ff;
      ringing_in = ringing_ff;
      acked_in   = acked_ff;
      tok_in_nxt = tok_in;

      if (tok_in_valid) begin
         case (tok_in.op)
            OP_TICK: begin
               if (stored && enabled_ff) begin
                  if (ringing_ff) begin
                     if (timed_out) begin
                        ringing_in      = 1'b0;
                        tok_in_nxt.stop = 1'b1;
                     end
                  end else if (matched) begin
                     if (!acked_ff) begin
                        ringing_in       = 1'b1;
                        tok_in_nxt.start = 1'b1;
                     end
                  end else begin
                     acked_in = 1'b0;
                  end
               end
            end
            OP_ADD: begin
               // The new entry goes right behind the last stored one.
               if (id_ext == cb_ext) begin
                  hour_in    = tok_in.hv;
                  minute_in  = tok_in.mv;
                  enabled_in = tok_in.ev;
                  ringing_in = 1'b0;
                  acked_in   = 1'b0;
               end
            end
            OP_MODIFY: begin
               if (addressed) begin
                  hour_in    = tok_in.hv;
                  minute_in  = tok_in.mv;
                  enabled_in = tok_in.ev;
                  acked_in   = 1'b0;
               end
            end
            OP_SET_EN: begin
               if (addressed) begin
                  enabled_in = tok_in.ev;
                  acked_in   = 1'b0;
               end
            end
            OP_CLEAR: begin
               ringing_in = 1'b0;
               acked_in   = 1'b0;
            end
            OP_ACK: begin
               if (stored && ringing_ff) begin
                  ringing_in      = 1'b0;
                  acked_in        = 1'b1;
                  tok_in_nxt.stop = 1'b1;
               end
            end
            default: begin
            end
         endcase

         if ((id_ext < ca_ext) && ringing_in) begin
            tok_in_nxt.any = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ringing_ff <= 1'b0;
         acked_ff   <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         ringing_ff <= ringing_in;
         acked_ff   <= acked_in;
         valid_ff   <= tok_in_valid;
      end
   end

   always_ff @(posedge clock) begin
      hour_ff    <= hour_in;
      minute_ff  <= minute_in;
      enabled_ff <= enabled_in;
      tok_ff     <= tok_in_nxt;
   end

   assign tok_out_valid = valid_ff;
   assign tok_out       = tok_ff;

endmodule

`default_nettype wire

// ----- test/tb_alarm_table_matcher.sv -----
// Testbench for alarm_table_matcher: random and directed alarm-table operations checked
// against a scoreboard that tracks the table. Depends on atm_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_alarm_table_matcher;
   import atm_pkg::*;

   localparam logic [2:0] OP_SPARE_A   = 3'd6;
   localparam logic [2:0] OP_SPARE_B   = 3'd7;
   localparam logic [2:0] TIMEOUT_ADDR = 3'd0;
   localparam int MINUTES_PER_DAY = HOURS_PER_DAY * MINUTES_PER_HOUR;
   localparam int QUIET_LIMIT     = 3000;
   localparam int HOLD_CYCLES     = 300;
   localparam int PHASE_ITEMS     = 325;

   // Tracks the alarm table and holds the results that the block still owes.
   class alarm_scoreboard;
      bit [4:0]         hour_tab[NUM_ALARMS];
      bit [5:0]         minute_tab[NUM_ALARMS];
      bit               enabled_tab[NUM_ALARMS];
      bit               ringing_tab[NUM_ALARMS];
      bit               acked_tab[NUM_ALARMS];
      int               stored;
      bit [TIMEOUT_W-1:0] timeout;
      rsp_type          owed_rsps[$];
      int               errors;
      int               items_seen;
      int               results_seen;

      function new();
         stored = 0;
         timeout = TIMEOUT_W'(TIMEOUT_RESET);
         errors = 0;
         items_seen = 0;
         results_seen = 0;
         foreach (ringing_tab[i]) begin
            hour_tab[i] = '0;
            minute_tab[i] = '0;
            enabled_tab[i] = 1'b0;
            ringing_tab[i] = 1'b0;
            acked_tab[i] = 1'b0;
         end
      endfunction

      function void note_request(req_type it);
         rsp_type r;
         int      h;
         int      elapsed;
         r = '0;
         r.error_code = ERR_OK;
         items_seen++;
         case (it.opcode)
            OP_TICK: begin
               for (int i = 0; i < stored; i++) begin
                  if (!enabled_tab[i])
                     continue;
                  if (ringing_tab[i]) begin
                     h = it.hour_value;
                     if (it.hour_value < hour_tab[i])
                        h += HOURS_PER_DAY;
                     elapsed = (h - int'(hour_tab[i])) * MINUTES_PER_HOUR
                               + (int'(it.minute_value) - int'(minute_tab[i]));
                     if (elapsed > int'(timeout)) begin
                        ringing_tab[i] = 1'b0;
                        r.stop_ring = 1'b1;
                     end
                  end else if (it.hour_value == hour_tab[i] &&
                               it.minute_value == minute_tab[i]) begin
                     if (!acked_tab[i]) begin
                        ringing_tab[i] = 1'b1;
                        r.start_ring = 1'b1;
                     end
                  end else begin
                     acked_tab[i] = 1'b0;
                  end
               end
            end
            OP_ADD: begin
               if (stored >= NUM_ALARMS) begin
                  r.error_code = ERR_FULL;
               end else begin
                  hour_tab[stored] = it.hour_value;
                  minute_tab[stored] = it.minute_value;
                  enabled_tab[stored] = it.enable_value;
                  ringing_tab[stored] = 1'b0;
                  acked_tab[stored] = 1'b0;
                  stored++;
               end
            end
            OP_MODIFY, OP_SET_EN: begin
               if (it.entry_index >= stored) begin
                  r.error_code = ERR_INDEX;
               end else begin
                  if (it.opcode == OP_MODIFY) begin
                     hour_tab[it.entry_index] = it.hour_value;
                     minute_tab[it.entry_index] = it.minute_value;
                  end
                  enabled_tab[it.entry_index] = it.enable_value;
                  acked_tab[it.entry_index] = 1'b0;
               end
            end
            OP_CLEAR: begin
               stored = 0;
               foreach (ringing_tab[i]) begin
                  ringing_tab[i] = 1'b0;
                  acked_tab[i] = 1'b0;
               end
            end
            OP_ACK: begin
               for (int i = 0; i < stored; i++) begin
                  if (ringing_tab[i]) begin
                     ringing_tab[i] = 1'b0;
                     acked_tab[i] = 1'b1;
                     r.stop_ring = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         for (int i = 0; i < stored; i++)
            if (ringing_tab[i])
               r.ringing = 1'b1;
         r.alarm_count = stored[3:0];
         owed_rsps.push_back(r);
      endfunction

      function void check_field(string what, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         results_seen++;
         if (owed_rsps.size() == 0) begin
            $display("%0t: result with no item pending, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         want = owed_rsps.pop_front();
         check_field("start_ring", want.start_ring, got.start_ring);
         check_field("stop_ring", want.stop_ring, got.stop_ring);
         check_field("ringing", want.ringing, got.ringing);
         check_field("alarm_count", want.alarm_count, got.alarm_count);
         check_field("error_code", want.error_code, got.error_code);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   alarm_scoreboard sb;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int clock_minutes = 0;

   alarm_table_matcher dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_payload);
         if (req_valid && req_ready)
            sb.note_request(req_payload);
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served = holds_asked;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (psel && penable && pready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send_item(req_type it);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= it;
      do
         @(posedge clock);
      while (!(req_valid && req_ready));
   endtask

   task automatic send_fields(logic [2:0] op, logic [2:0] idx, logic [4:0] hv,
                              logic [5:0] mv, logic ev);
      req_type it;
      it.opcode = op;
      it.entry_index = idx;
      it.hour_value = hv;
      it.minute_value = mv;
      it.enable_value = ev;
      send_item(it);
   endtask

   // Waits until every owed result has come, then lets the pipeline settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.owed_rsps.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_timeout(bit [TIMEOUT_W-1:0] value);
      logic [31:0] got;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= TIMEOUT_ADDR;
      pwdata <= {{(32 - TIMEOUT_W){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      sb.timeout = value;
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      got = prdata;
      do
         @(posedge clock);
      while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      if (got !== {{(32 - TIMEOUT_W){1'b0}}, value}) begin
         $display("%0t: timeout readback mismatch, expected %0d, actual %0d",
                  $time, value, got);
         sb.errors++;
      end
   endtask

   // Mostly a walking wall clock with alarms set just ahead of it, so that
   // alarms actually ring, time out and get acknowledged.
   function automatic req_type random_item();
      req_type it;
      int      pick;
      int      t;
      int      alarm_at;
      it.opcode = OP_TICK;
      it.entry_index = 3'($urandom_range(7));
      it.hour_value = 5'($urandom_range(31));
      it.minute_value = 6'($urandom_range(63));
      it.enable_value = 1'($urandom_range(1));
      pick = $urandom_range(99);
      alarm_at = (clock_minutes + $urandom_range(15)) % MINUTES_PER_DAY;
      if ($urandom_range(99) < 15)
         alarm_at = $urandom_range(MINUTES_PER_DAY - 1);
      if (pick < 46) begin
         t = $urandom_range(99);
         if (t >= 4) begin
            if (t < 9)
               clock_minutes = (clock_minutes + $urandom_range(MINUTES_PER_DAY - 1))
                               % MINUTES_PER_DAY;
            else
               clock_minutes = (clock_minutes + $urandom_range(3)) % MINUTES_PER_DAY;
            it.hour_value = 5'(clock_minutes / MINUTES_PER_HOUR);
            it.minute_value = 6'(clock_minutes % MINUTES_PER_HOUR);
         end
      end else if (pick < 68) begin
         it.opcode = (pick < 60) ? OP_ADD : OP_MODIFY;
         it.hour_value = 5'(alarm_at / MINUTES_PER_HOUR);
         it.minute_value = 6'(alarm_at % MINUTES_PER_HOUR);
         it.enable_value = ($urandom_range(99) < 85);
      end else if (pick < 76) begin
         it.opcode = OP_SET_EN;
         it.enable_value = ($urandom_range(99) < 80);
      end else if (pick < 86) begin
         it.opcode = OP_ACK;
      end else if (pick < 88) begin
         it.opcode = OP_CLEAR;
      end else if (pick < 91) begin
         it.opcode = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
      end else begin
         it.opcode = 3'($urandom_range(7));
      end
      return it;
   endfunction

   task automatic run_phase(int sidle, int rstall, int tmo, bit hold_off);
      drain();
      write_timeout(TIMEOUT_W'(tmo));
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      if (hold_off)
         holds_asked = holds_asked + 1;
      repeat (PHASE_ITEMS)
         send_item(random_item());
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_timeout(TIMEOUT_W'(TIMEOUT_RESET));

      // Directed part: empty table, bad indices, wrap past midnight,
      // acknowledge, disabled ringing entry, early time, odd times, full table.
      send_fields(OP_TICK,    3'd0, 5'd0,  6'd0,  1'b0);
      send_fields(OP_MODIFY,  3'd0, 5'd1,  6'd1,  1'b1);
      send_fields(OP_SET_EN,  3'd7, 5'd0,  6'd0,  1'b1);
      send_fields(OP_ADD,     3'd5, 5'd23, 6'd59, 1'b1);
      send_fields(OP_ADD,     3'd0, 5'd0,  6'd0,  1'b1);
      send_fields(OP_ADD,     3'd0, 5'd12, 6'd30, 1'b0);
      send_fields(OP_TICK,    3'd0, 5'd23, 6'd59, 1'b0);
      send_fields(OP_TICK,    3'd0, 5'd0,  6'd0,  1'b0);
      send_fields(OP_ACK,     3'd0, 5'd0,  6'd0,  1'b0);
      send_fields(OP_TICK,    3'd0, 5'd0,  6'd0,  1'b0);
      send_fields(OP_TICK,    3'd0, 5'd0,  6'd1,  1'b0);
      send_fields(OP_SET_EN,  3'd2, 5'd0,  6'd0,  1'b1);
      send_fields(OP_TICK,    3'd0, 5'd12, 6'd30, 1'b0);
      send_fields(OP_SET_EN,  3'd2, 5'd0,  6'd0,  1'b0);
      send_fields(OP_TICK,    3'd0, 5'd23, 6'd0,  1'b0);
      send_fields(OP_MODIFY,  3'd2, 5'd12, 6'd29, 1'b1);
      send_fields(OP_TICK,    3'd0, 5'd12, 6'd28, 1'b0);
      send_fields(OP_TICK,    3'd7, 5'd31, 6'd63, 1'b1);
      repeat (5)
         send_fields(OP_ADD, 3'd7, 5'd31, 6'd63, 1'b1);
      send_fields(OP_ADD,     3'd0, 5'd1,  6'd2,  1'b1);
      send_fields(OP_SPARE_A, 3'd7, 5'd31, 6'd63, 1'b1);
      send_fields(OP_SPARE_B, 3'd0, 5'd0,  6'd0,  1'b0);
      send_fields(OP_CLEAR,   3'd0, 5'd0,  6'd0,  1'b0);

      run_phase(0, 0, 0, 1'b0);
      run_phase(62, 0, (1 << TIMEOUT_W) - 609, 1'b0);
      run_phase(0, 62, $urandom_range(MINUTES_PER_DAY - 1), 1'b0);
      run_phase(7, 7, $urandom_range(MINUTES_PER_DAY - 1), 1'b0);
      run_phase(0, 0, $urandom_range(1, 60), 1'b1);
      drain();
      repeat (8) @(posedge clock);

      $display("Run summary: %0d items sent, %0d results checked, %0d mismatches.",
               sb.items_seen, sb.results_seen, sb.errors);
      $display("Timeouts 0, 30, 1439 and random; four idle/stall mixes and one long hold-off.");
      if (sb.errors == 0 && sb.owed_rsps.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
